// ===== hw/rtl/seqnum_reorder_resend_buffer_top_defines.svh =====
// Assertion macros for the sequence-number reorder/resend buffer.
// Used by the port checker; expects clk and rst in scope.
`ifndef SEQNUM_REORDER_RESEND_BUFFER_TOP_DEFINES_SVH
`define SEQNUM_REORDER_RESEND_BUFFER_TOP_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define SRRB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srrb port check failed");

// Next-cycle implication, gated off during reset.
`define SRRB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srrb port check failed");

`endif

// ===== hw/rtl/srrb_pkg.sv =====
// Shared types and constants for the sequence-number reorder/resend buffer.
// No dependencies; used by the top level and the port checker.
package srrb_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_TYPE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd3;

  localparam logic [2:0] FN_INSERT    = 3'd0;
  localparam logic [2:0] FN_POP_FIRST = 3'd1;
  localparam logic [2:0] FN_POP_NUM   = 3'd2;
  localparam logic [2:0] FN_PEEK      = 3'd3;
  localparam logic [2:0] FN_TICK      = 3'd4;
  localparam logic [2:0] FN_COUNT     = 3'd5;
  localparam logic [2:0] FN_RESEND    = 3'd6;
  localparam logic [2:0] FN_RESERVED  = 3'd7;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_BAD_SIZE    = 4'd1;
  localparam logic [3:0] ST_BAD_TYPE    = 4'd2;
  localparam logic [3:0] ST_OUT_WINDOW  = 4'd3;
  localparam logic [3:0] ST_IS_NEXT     = 4'd4;
  localparam logic [3:0] ST_DUP_IGNORED = 4'd5;
  localparam logic [3:0] ST_DUP_MISMATCH = 4'd6;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd7;
  localparam logic [3:0] ST_NOTHING     = 4'd8;

  localparam logic [5:0] MAX_RESULTS = 6'd32;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] seq_number;
    logic [15:0] rx_next_seq;
    logic [7:0]  packet_type;
    logic [15:0] packet_size;
    logic [31:0] source_tag;
    logic [15:0] packet_handle;
    logic [15:0] elapsed_ms;
    logic [23:0] timeout_ms;
    logic [5:0]  max_resend;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] out_seq_number;
    logic [15:0] out_handle;
    logic [15:0] oldest_unacked;
    logic [6:0]  entry_count;
    logic [6:0]  timed_out_count;
    logic        dropped_oldest;
    logic        last;
  } rsp_t;

endpackage

// ===== hw/rtl/seqnum_reorder_resend_buffer_top.sv =====
// Sequence-number reorder/resend buffer, top level. Depends on srrb_pkg.
// One request at a time: req_stall is high outside the idle state. A resend
//   streams up to 32 responses, each held back while the output is stalled.
// Reset: rst is synchronous, active high; clears count, head and rsp_valid, loads the
//   default config. The entry RAM is not cleared (only entries below count are read).
module seqnum_reorder_resend_buffer_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  srrb_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output srrb_pkg::rsp_t                      rsp,
  input  logic                                cfg_we,
  input  logic [srrb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srrb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = srrb_pkg::AW;
  localparam int CW = srrb_pkg::CW;

  // One entry of the list; all fields live in one RAM word.
  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] handle;
    logic [15:0] size;
    logic [31:0] source;
    logic [31:0] since_ms;
    logic [31:0] total_ms;
    logic [23:0] backoff;   // Q16.8
  } entry_t;

  // Sequencer states. Each list walk is NEXT (bounds check, set read
  // address), READ (RAM latency) and a use state; resend uses MUL, CMP, UPD and EMIT.
  typedef enum logic [31:0] {
    S_IDLE    = 32'd1 << 0,
    S_INS_CHK = 32'd1 << 1,
    S_RM_NEXT = 32'd1 << 2,
    S_RM_READ = 32'd1 << 3,
    S_RM_WR   = 32'd1 << 4,
    S_SR_NEXT = 32'd1 << 5,
    S_SR_READ = 32'd1 << 6,
    S_SR_CHK  = 32'd1 << 7,
    S_SU_NEXT = 32'd1 << 8,
    S_SU_READ = 32'd1 << 9,
    S_SU_WR   = 32'd1 << 10,
    S_FH      = 32'd1 << 11,
    S_FH_READ = 32'd1 << 12,
    S_FH_SET  = 32'd1 << 13,
    S_PK_READ = 32'd1 << 14,
    S_PK_USE  = 32'd1 << 15,
    S_PN_NEXT = 32'd1 << 16,
    S_PN_READ = 32'd1 << 17,
    S_PN_CHK  = 32'd1 << 18,
    S_TK_NEXT = 32'd1 << 19,
    S_TK_READ = 32'd1 << 20,
    S_TK_WR   = 32'd1 << 21,
    S_CT_NEXT = 32'd1 << 22,
    S_CT_READ = 32'd1 << 23,
    S_CT_CHK  = 32'd1 << 24,
    S_RS_NEXT = 32'd1 << 25,
    S_RS_READ = 32'd1 << 26,
    S_RS_MUL  = 32'd1 << 27,
    S_RS_CMP  = 32'd1 << 28,
    S_RS_UPD  = 32'd1 << 29,
    S_RS_EMIT = 32'd1 << 30,
    S_EMIT    = 32'd1 << 31
  } state_t;

  state_t state;

  // Configuration registers
  logic [15:0] window;
  logic [15:0] min_size;
  logic [7:0]  rel_type;
  logic [9:0]  scale;

  // Request context and list bookkeeping
  srrb_pkg::req_t cur;
  logic [CW-1:0]  cnt;
  logic [15:0]    head;
  logic [CW-1:0]  ptr;        // walk index / RAM write target
  logic [CW-1:0]  pos;        // insert position
  logic [AW-1:0]  raddr;
  logic [5:0]     n;          // resend results so far
  logic [5:0]     maxp;

  // Pending result fields. For resend, res_seq/res_handle hold the
  // previous hit until we know whether it is the last one.
  logic [3:0]  res_status;
  logic [15:0] res_seq;
  logic [15:0] res_handle;
  logic [6:0]  res_tcount;
  logic        res_drop;
  logic        held_valid;
  logic [15:0] cand_seq;
  logic [15:0] cand_handle;

  // Entry RAM
  entry_t        mem [srrb_pkg::DEPTH];
  entry_t        rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  entry_t        mem_wd;

  // Shared multiplier: timeout*backoff for the resend test, then
  // backoff*scale for the new backoff.
  logic [23:0] mul_b;
  logic [47:0] prod;

  logic           out_free;
  logic           out_load;
  srrb_pkg::rsp_t out_item;

  logic [15:0]   win_end;
  logic          in_win;
  logic          cont;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] ptr_dec;
  logic [32:0]   since_sum;
  logic [32:0]   total_sum;
  logic [39:0]   nb_full;
  logic [23:0]   nb;
  logic          qualifies;
  logic [5:0]    maxp_c;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;
  assign ptr_inc   = ptr + CW'(1);
  assign ptr_dec   = ptr - CW'(1);

  // Window test: [next, next+window) modulo 2^16
  assign win_end = cur.rx_next_seq + window;
  assign in_win  = (cur.rx_next_seq < win_end) ?
                   (cur.seq_number >= cur.rx_next_seq && cur.seq_number < win_end) :
                   (cur.seq_number < win_end || cur.seq_number >= cur.rx_next_seq);

  // Wrap-aware ordering: keep walking while the entry sorts before the new number
  assign cont = (cur.seq_number < cur.rx_next_seq) ?
                (rd_q.seq < cur.seq_number || rd_q.seq >= cur.rx_next_seq) :
                (rd_q.seq < cur.seq_number && rd_q.seq >= cur.rx_next_seq);

  // Saturating timer adds for tick
  assign since_sum = {1'b0, rd_q.since_ms} + {17'd0, cur.elapsed_ms};
  assign total_sum = {1'b0, rd_q.total_ms} + {17'd0, cur.elapsed_ms};

  // Resend test is exact: since*256 >= timeout*backoff
  assign qualifies = ({8'd0, rd_q.since_ms, 8'd0} >= prod);
  assign nb_full   = prod[47:8];
  assign nb        = (|nb_full[39:24]) ? 24'hFF_FFFF : nb_full[23:0];

  assign mul_b = (state == S_RS_CMP) ? {14'd0, scale} : cur.timeout_ms;

  assign maxp_c = (req.max_resend == 6'd0) ? 6'd1 :
                  (req.max_resend > srrb_pkg::MAX_RESULTS) ? srrb_pkg::MAX_RESULTS :
                  req.max_resend;

  always_ff @(posedge clk) begin
    prod <= rd_q.backoff * mul_b;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[raddr];
  end

  // RAM write and output load decode
  always_comb begin
    mem_we   = 1'b0;
    mem_wa   = ptr[AW-1:0];
    mem_wd   = rd_q;
    out_load = 1'b0;
    out_item = '{status: res_status, out_seq_number: res_seq, out_handle: res_handle,
                 oldest_unacked: head, entry_count: 7'(cnt), timed_out_count: res_tcount,
                 dropped_oldest: res_drop, last: 1'b1};
    unique case (state)
      S_RM_WR, S_SU_WR: begin
        mem_we = 1'b1;
      end
      S_SU_NEXT: begin
        if (ptr <= pos) begin
          mem_we = 1'b1;
          mem_wa = pos[AW-1:0];
          mem_wd = '{seq: cur.seq_number, handle: cur.packet_handle,
                     size: cur.packet_size, source: cur.source_tag,
                     since_ms: 32'd0, total_ms: 32'd0, backoff: 24'd256};
        end
      end
      S_TK_WR: begin
        mem_we = 1'b1;
        mem_wd.since_ms = since_sum[32] ? 32'hFFFF_FFFF : since_sum[31:0];
        mem_wd.total_ms = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
      end
      S_RS_UPD: begin
        mem_we = 1'b1;
        mem_wd.since_ms = 32'd0;
        mem_wd.backoff  = nb;
      end
      S_RS_EMIT: begin
        // flush the previous hit; it is not the last one
        out_load = held_valid && out_free;
        out_item.status = srrb_pkg::ST_OK;
        out_item.last   = 1'b0;
      end
      S_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      head       <= '0;
      rsp_valid  <= 1'b0;
      held_valid <= 1'b0;
      window     <= 16'd32768;
      min_size   <= 16'd10;
      rel_type   <= 8'd3;
      scale      <= 10'd384;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          srrb_pkg::CFG_WINDOW:   window   <= cfg_data;
          srrb_pkg::CFG_MIN_SIZE: min_size <= cfg_data;
          srrb_pkg::CFG_REL_TYPE: rel_type <= cfg_data[7:0];
          srrb_pkg::CFG_SCALE:    scale    <= cfg_data[9:0];
        endcase
      end

      // out_load implies the register is free
      if (out_load) begin
        rsp_valid <= 1'b1;
        rsp       <= out_item;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur        <= req;
            res_status <= ((req.func == srrb_pkg::FN_POP_FIRST ||
                            req.func == srrb_pkg::FN_PEEK) && cnt == '0) ?
                          srrb_pkg::ST_NOT_FOUND : srrb_pkg::ST_OK;
            res_seq    <= '0;
            res_handle <= '0;
            res_tcount <= '0;
            res_drop   <= 1'b0;
            held_valid <= 1'b0;
            n          <= '0;
            ptr        <= '0;
            maxp       <= maxp_c;
            raddr      <= '0;
            unique case (req.func) inside
              srrb_pkg::FN_INSERT: state <= S_INS_CHK;
              srrb_pkg::FN_POP_FIRST, srrb_pkg::FN_PEEK: begin
                state <= (cnt == '0) ? S_EMIT : S_PK_READ;
              end
              srrb_pkg::FN_POP_NUM: state <= S_PN_NEXT;
              srrb_pkg::FN_TICK:    state <= S_TK_NEXT;
              srrb_pkg::FN_COUNT:   state <= S_CT_NEXT;
              srrb_pkg::FN_RESEND:  state <= S_RS_NEXT;
              default:              state <= S_EMIT;
            endcase
          end
        end

        S_INS_CHK: begin
          if (cur.packet_size < min_size) begin
            res_status <= srrb_pkg::ST_BAD_SIZE;
            state      <= S_EMIT;
          end else if (cur.packet_type != rel_type) begin
            res_status <= srrb_pkg::ST_BAD_TYPE;
            state      <= S_EMIT;
          end else if (!in_win) begin
            res_status <= srrb_pkg::ST_OUT_WINDOW;
            state      <= S_EMIT;
          end else if (cur.seq_number == cur.rx_next_seq) begin
            res_status <= srrb_pkg::ST_IS_NEXT;
            state      <= S_EMIT;
          end else if (cnt >= CW'(srrb_pkg::DEPTH)) begin
            // full: drop the head first
            res_drop <= 1'b1;
            ptr      <= '0;
            state    <= S_RM_NEXT;
          end else begin
            ptr   <= '0;
            state <= S_SR_NEXT;
          end
        end

        // remove entry at ptr: close the gap one entry at a time
        S_RM_NEXT: begin
          if (ptr_inc < cnt) begin
            raddr <= ptr_inc[AW-1:0];
            state <= S_RM_READ;
          end else begin
            cnt <= cnt - CW'(1);
            if (cur.func == srrb_pkg::FN_INSERT) begin
              ptr   <= '0;
              state <= S_SR_NEXT;
            end else begin
              state <= S_FH;
            end
          end
        end
        S_RM_READ: state <= S_RM_WR;
        S_RM_WR: begin
          ptr   <= ptr_inc;
          state <= S_RM_NEXT;
        end

        // insert position search
        S_SR_NEXT: begin
          if (ptr < cnt) begin
            raddr <= ptr[AW-1:0];
            state <= S_SR_READ;
          end else begin
            pos   <= ptr;
            state <= S_SU_NEXT;
          end
        end
        S_SR_READ: state <= S_SR_CHK;
        S_SR_CHK: begin
          if (cont) begin
            ptr   <= ptr_inc;
            state <= S_SR_NEXT;
          end else if (rd_q.seq == cur.seq_number) begin
            res_status <= (rd_q.size == cur.packet_size && rd_q.source == cur.source_tag) ?
                          srrb_pkg::ST_DUP_IGNORED : srrb_pkg::ST_DUP_MISMATCH;
            state      <= S_FH;
          end else begin
            pos   <= ptr;
            ptr   <= cnt;
            state <= S_SU_NEXT;
          end
        end

        // open a gap at pos, then write the new entry there
        S_SU_NEXT: begin
          if (ptr > pos) begin
            raddr <= ptr_dec[AW-1:0];
            state <= S_SU_READ;
          end else begin
            cnt   <= cnt + CW'(1);
            state <= S_FH;
          end
        end
        S_SU_READ: state <= S_SU_WR;
        S_SU_WR: begin
          ptr   <= ptr_dec;
          state <= S_SU_NEXT;
        end

        // refresh head from entry 0
        S_FH: begin
          if (cnt == '0) begin
            head  <= '0;
            state <= S_EMIT;
          end else begin
            raddr <= '0;
            state <= S_FH_READ;
          end
        end
        S_FH_READ: state <= S_FH_SET;
        S_FH_SET: begin
          head  <= rd_q.seq;
          state <= S_EMIT;
        end

        // pop first / peek
        S_PK_READ: state <= S_PK_USE;
        S_PK_USE: begin
          res_seq    <= rd_q.seq;
          res_handle <= rd_q.handle;
          if (cur.func == srrb_pkg::FN_POP_FIRST) begin
            ptr   <= '0;
            state <= S_RM_NEXT;
          end else begin
            state <= S_EMIT;
          end
        end

        // pop by number
        S_PN_NEXT: begin
          if (ptr < cnt) begin
            raddr <= ptr[AW-1:0];
            state <= S_PN_READ;
          end else begin
            res_status <= srrb_pkg::ST_NOT_FOUND;
            state      <= S_EMIT;
          end
        end
        S_PN_READ: state <= S_PN_CHK;
        S_PN_CHK: begin
          if (rd_q.seq == cur.seq_number) begin
            res_seq    <= cur.seq_number;
            res_handle <= rd_q.handle;
            state      <= S_RM_NEXT;
          end else begin
            ptr   <= ptr_inc;
            state <= S_PN_NEXT;
          end
        end

        // tick
        S_TK_NEXT: begin
          if (ptr < cnt) begin
            raddr <= ptr[AW-1:0];
            state <= S_TK_READ;
          end else begin
            state <= S_EMIT;
          end
        end
        S_TK_READ: state <= S_TK_WR;
        S_TK_WR: begin
          ptr   <= ptr_inc;
          state <= S_TK_NEXT;
        end

        // count timed out
        S_CT_NEXT: begin
          if (ptr < cnt) begin
            raddr <= ptr[AW-1:0];
            state <= S_CT_READ;
          end else begin
            state <= S_EMIT;
          end
        end
        S_CT_READ: state <= S_CT_CHK;
        S_CT_CHK: begin
          if (rd_q.total_ms >= {8'd0, cur.timeout_ms}) begin
            res_tcount <= res_tcount + 7'd1;
          end
          ptr   <= ptr_inc;
          state <= S_CT_NEXT;
        end

        // resend walk
        S_RS_NEXT: begin
          if (ptr < cnt && n < maxp) begin
            raddr <= ptr[AW-1:0];
            state <= S_RS_READ;
          end else begin
            if (!held_valid) begin
              res_status <= srrb_pkg::ST_NOTHING;
            end
            state <= S_EMIT;
          end
        end
        S_RS_READ: state <= S_RS_MUL;
        S_RS_MUL:  state <= S_RS_CMP;
        S_RS_CMP: begin
          if (qualifies) begin
            state <= S_RS_UPD;
          end else begin
            ptr   <= ptr_inc;
            state <= S_RS_NEXT;
          end
        end
        S_RS_UPD: begin
          cand_seq    <= rd_q.seq;
          cand_handle <= rd_q.handle;
          state       <= S_RS_EMIT;
        end
        S_RS_EMIT: begin
          if (!held_valid || out_free) begin
            res_seq    <= cand_seq;
            res_handle <= cand_handle;
            held_valid <= 1'b1;
            n          <= n + 6'd1;
            ptr        <= ptr_inc;
            state      <= S_RS_NEXT;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/srrb_checker.sv =====
// Port-level checker for the reorder/resend buffer, bound to the top level.
// Depends on srrb_pkg and seqnum_reorder_resend_buffer_top_defines.svh.
`include "seqnum_reorder_resend_buffer_top_defines.svh"

module srrb_port_assert (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input srrb_pkg::rsp_t rsp
);

  `SRRB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `SRRB_ASSERT_NOW(a_count_max, rsp_valid, rsp.entry_count <= 7'(srrb_pkg::DEPTH))
  `SRRB_ASSERT_NOW(a_head_empty, rsp_valid && rsp.entry_count == 7'd0, rsp.oldest_unacked == 16'd0)
  `SRRB_ASSERT_NOW(a_nonlast_ok, rsp_valid && !rsp.last, rsp.status == srrb_pkg::ST_OK)

endmodule

bind seqnum_reorder_resend_buffer_top srrb_port_assert u_srrb_port_assert (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

// ===== tb/srrb_checker.sv =====
`timescale 1ns / 100ps
// Checker for the reorder/resend buffer: watches the request, response and config ports,
// predicts every response and compares it. Depends on srrb_pkg.
module srrb_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_stall,
  input  srrb_pkg::req_t                  req,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  srrb_pkg::rsp_t                  rsp,
  input  logic                            cfg_we,
  input  logic [srrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [srrb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending
);
  import srrb_pkg::*;

  logic [15:0] win_q, min_size_q;
  logic [7:0]  rel_type_q;
  logic [9:0]  scale_q;

  logic [15:0] ent_seq [DEPTH];
  logic [15:0] ent_hdl [DEPTH];
  logic [15:0] ent_size [DEPTH];
  logic [31:0] ent_src [DEPTH];
  logic [31:0] ent_since [DEPTH];
  logic [31:0] ent_total [DEPTH];
  logic [23:0] ent_boff [DEPTH];
  int          held;

  rsp_t expected_rsps[$];

  initial begin
    errors  = 0;
    pending = 0;
    held    = 0;
  end

  task automatic add_rsp(input logic [3:0] st, input logic [15:0] sq, input logic [15:0] hd,
                         input logic [6:0] tc, input logic dr);
    rsp_t r;
    r.status          = st;
    r.out_seq_number  = sq;
    r.out_handle      = hd;
    r.oldest_unacked  = (held != 0) ? ent_seq[0] : 16'd0;
    r.entry_count     = held[6:0];
    r.timed_out_count = tc;
    r.dropped_oldest  = dr;
    r.last            = 1'b0;
    expected_rsps.insert(expected_rsps.size(), r);
  endtask

  task automatic copy_entry(input int to, input int from);
    ent_seq[to]   = ent_seq[from];
    ent_hdl[to]   = ent_hdl[from];
    ent_size[to]  = ent_size[from];
    ent_src[to]   = ent_src[from];
    ent_since[to] = ent_since[from];
    ent_total[to] = ent_total[from];
    ent_boff[to]  = ent_boff[from];
  endtask

  task automatic drop_entry(input int i);
    for (int j = i; j + 1 < held; j++) copy_entry(j, j + 1);
    held--;
  endtask

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] b);
    logic [32:0] s;
    s = a + b;
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic insert_pkt(input req_t r);
    logic [15:0] s, ne, wend, e;
    logic        inwin, dropped, cont;
    int          pos;
    s = r.seq_number;
    ne = r.rx_next_seq;
    wend = ne + win_q;
    dropped = 1'b0;
    inwin = (ne < wend) ? (s >= ne && s < wend) : (s < wend || s >= ne);
    if (r.packet_size < min_size_q) add_rsp(ST_BAD_SIZE, 0, 0, 0, 0);
    else if (r.packet_type != rel_type_q) add_rsp(ST_BAD_TYPE, 0, 0, 0, 0);
    else if (!inwin) add_rsp(ST_OUT_WINDOW, 0, 0, 0, 0);
    else if (s == ne) add_rsp(ST_IS_NEXT, 0, 0, 0, 0);
    else begin
      // full list: head goes before the duplicate search
      if (held >= DEPTH) begin
        drop_entry(0);
        dropped = 1'b1;
      end
      // wrap-aware position relative to next expected
      for (pos = 0; pos < held; pos++) begin
        e = ent_seq[pos];
        cont = (s < ne) ? (e < s || e >= ne) : (e < s && e >= ne);
        if (!cont) break;
      end
      if (pos < held && ent_seq[pos] == s) begin
        add_rsp((ent_size[pos] == r.packet_size && ent_src[pos] == r.source_tag) ?
                ST_DUP_IGNORED : ST_DUP_MISMATCH, 0, 0, 0, dropped);
      end else begin
        for (int j = held; j > pos; j--) copy_entry(j, j - 1);
        ent_seq[pos]   = s;
        ent_hdl[pos]   = r.packet_handle;
        ent_size[pos]  = r.packet_size;
        ent_src[pos]   = r.source_tag;
        ent_since[pos] = 0;
        ent_total[pos] = 0;
        ent_boff[pos]  = 24'd256;
        held++;
        add_rsp(ST_OK, 0, 0, 0, dropped);
      end
    end
  endtask

  task automatic resend_pkts(input req_t r);
    int          maxp, n;
    logic [63:0] lhs, rhs, nb;
    maxp = (r.max_resend == 0) ? 1 : r.max_resend;
    if (maxp > MAX_RESULTS) maxp = MAX_RESULTS;
    n = 0;
    for (int i = 0; i < held && n < maxp; i++) begin
      lhs = {24'd0, ent_since[i], 8'd0};
      rhs = 64'(r.timeout_ms) * 64'(ent_boff[i]);
      if (lhs >= rhs) begin
        ent_since[i] = 0;
        nb = (64'(ent_boff[i]) * 64'(scale_q)) >> 8;
        ent_boff[i] = (nb > 64'hFF_FFFF) ? 24'hFF_FFFF : nb[23:0];
        add_rsp(ST_OK, ent_seq[i], ent_hdl[i], 0, 0);
        n++;
      end
    end
    if (n == 0) add_rsp(ST_NOTHING, 0, 0, 0, 0);
  endtask

  task automatic apply_req(input req_t r);
    int   i, n;
    rsp_t tail;
    case (r.func)
      FN_INSERT: insert_pkt(r);
      FN_POP_FIRST, FN_PEEK: begin
        if (held == 0) add_rsp(ST_NOT_FOUND, 0, 0, 0, 0);
        else begin
          tail.out_seq_number = ent_seq[0];
          tail.out_handle     = ent_hdl[0];
          if (r.func == FN_POP_FIRST) drop_entry(0);
          add_rsp(ST_OK, tail.out_seq_number, tail.out_handle, 0, 0);
        end
      end
      FN_POP_NUM: begin
        for (i = 0; i < held && ent_seq[i] != r.seq_number; i++) ;
        if (i >= held) add_rsp(ST_NOT_FOUND, 0, 0, 0, 0);
        else begin
          tail.out_handle = ent_hdl[i];
          drop_entry(i);
          add_rsp(ST_OK, r.seq_number, tail.out_handle, 0, 0);
        end
      end
      FN_TICK: begin
        for (i = 0; i < held; i++) begin
          ent_since[i] = sat_add(ent_since[i], r.elapsed_ms);
          ent_total[i] = sat_add(ent_total[i], r.elapsed_ms);
        end
        add_rsp(ST_OK, 0, 0, 0, 0);
      end
      FN_COUNT: begin
        n = 0;
        for (i = 0; i < held; i++) if (ent_total[i] >= 32'(r.timeout_ms)) n++;
        add_rsp(ST_OK, 0, 0, n[6:0], 0);
      end
      FN_RESEND: resend_pkts(r);
      default: add_rsp(ST_OK, 0, 0, 0, 0);  // unused code: no effect
    endcase
    expected_rsps[expected_rsps.size() - 1].last = 1'b1;
  endtask

  task automatic report(input string fld, input logic [31:0] e, input logic [31:0] g);
    $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, fld, e, g);
  endtask

  task automatic check_rsp(input rsp_t g);
    rsp_t e;
    bit   bad;
    bad = 0;
    if (expected_rsps.size() == 0) begin
      $display("%0t: unexpected response: expected none, actual %p", $time, g);
      errors++;
      return;
    end
    e = expected_rsps[0];
    expected_rsps.delete(0);
    if (g.status !== e.status) begin report("status", e.status, g.status); bad = 1; end
    if (g.out_seq_number !== e.out_seq_number) begin
      report("out_seq_number", e.out_seq_number, g.out_seq_number); bad = 1;
    end
    if (g.out_handle !== e.out_handle) begin
      report("out_handle", e.out_handle, g.out_handle); bad = 1;
    end
    if (g.oldest_unacked !== e.oldest_unacked) begin
      report("oldest_unacked", e.oldest_unacked, g.oldest_unacked); bad = 1;
    end
    if (g.entry_count !== e.entry_count) begin
      report("entry_count", e.entry_count, g.entry_count); bad = 1;
    end
    if (g.timed_out_count !== e.timed_out_count) begin
      report("timed_out_count", e.timed_out_count, g.timed_out_count); bad = 1;
    end
    if (g.dropped_oldest !== e.dropped_oldest) begin
      report("dropped_oldest", e.dropped_oldest, g.dropped_oldest); bad = 1;
    end
    if (g.last !== e.last) begin report("last", e.last, g.last); bad = 1; end
    if (bad) errors++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      win_q      = 16'd32768;
      min_size_q = 16'd10;
      rel_type_q = 8'd3;
      scale_q    = 10'd384;
      held       = 0;
      expected_rsps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:   win_q      = cfg_data;
          CFG_MIN_SIZE: min_size_q = cfg_data;
          CFG_REL_TYPE: rel_type_q = cfg_data[7:0];
          CFG_SCALE:    scale_q    = cfg_data[9:0];
          default: ;
        endcase
      end
      // response first: it always belongs to an earlier request
      if (rsp_valid && !rsp_stall) check_rsp(rsp);
      if (req_valid && !req_stall) apply_req(req);
    end
    pending = expected_rsps.size();
  end

endmodule

// ===== tb/tb_seqnum_reorder_resend_buffer_top.sv =====
`timescale 1ns / 100ps
// Top of the reorder/resend buffer testbench: clock, reset, stimulus and verdict.
// Depends on srrb_pkg, seqnum_reorder_resend_buffer_top and srrb_checker.
module tb_seqnum_reorder_resend_buffer_top;
  import srrb_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int errors, pending;
  int cycles = 0;
  bit calm = 0;          // no idling on either side while set

  // local copy of the settings, used only to shape well-formed requests
  logic [15:0] cur_win = 16'd32768, cur_min = 16'd10;
  logic [7:0]  cur_type = 8'd3;
  logic [15:0] next_exp = 16'd0;

  // recently inserted packets, reused for duplicates and pop-by-number
  logic [15:0] seen_seq [16];
  logic [15:0] seen_size [16];
  logic [31:0] seen_src [16];
  int          seen_n = 0;

  seqnum_reorder_resend_buffer_top dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  srrb_checker chk (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    rsp_stall = !calm && ($urandom_range(0, 99) < 23);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
      $display("tb_seqnum_reorder_resend_buffer_top: FAIL");
      $finish;
    end
  end

  function automatic req_t mk(input logic [2:0] fn, input logic [15:0] sq, input logic [15:0] ne,
                              input logic [7:0] ty, input logic [15:0] sz, input logic [31:0] src,
                              input logic [15:0] hd, input logic [15:0] el,
                              input logic [23:0] to, input logic [5:0] mp);
    req_t r;
    r.func = fn; r.seq_number = sq; r.rx_next_seq = ne; r.packet_type = ty;
    r.packet_size = sz; r.source_tag = src; r.packet_handle = hd; r.elapsed_ms = el;
    r.timeout_ms = to; r.max_resend = mp;
    return r;
  endfunction

  // Present one request at the falling edge and hold it until accepted.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send(input req_t r);
    bit taken;
    if (!calm && $urandom_range(0, 99) < 23) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do begin
      #1 taken = !req_stall;   // stall is settled until the next rising edge
      @(negedge clk);
    end while (!taken);
  endtask

  task automatic wait_idle();
    req_valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] w, input logic [15:0] mn,
                           input logic [7:0] ty, input logic [9:0] sc);
    logic [15:0] vals [4];
    wait_idle();
    vals[0] = w; vals[1] = mn; vals[2] = {8'd0, ty}; vals[3] = {6'd0, sc};
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1'b1;
      cfg_index = i[CFG_IDX_W-1:0];
      cfg_data = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
    cur_win = w; cur_min = mn; cur_type = ty;
  endtask

  // Mostly well-formed traffic around a drifting next-expected number,
  // plus fully random noise that reaches every bit of every field.
  function automatic req_t rand_req(input int insert_pct);
    req_t         r;
    int           pick, k;
    logic [15:0]  off;
    logic [191:0] raw;
    r = mk(FN_INSERT, 0, next_exp, cur_type, 0, 32'($urandom_range(0, 3)),
           16'($urandom), 0, 0, 0);
    r.packet_size = cur_min + 16'($urandom_range(0, 65535 - cur_min));
    pick = $urandom_range(0, 99);
    if (pick < insert_pct) begin
      if (seen_n > 0 && $urandom_range(0, 99) < 20) begin
        // duplicate, matching half the time
        k = $urandom_range(0, seen_n - 1);
        r.seq_number = seen_seq[k];
        if ($urandom_range(0, 1)) begin
          r.packet_size = seen_size[k];
          r.source_tag = seen_src[k];
        end
      end else begin
        off = (cur_win > 1) ? 16'($urandom_range(1, cur_win - 1)) : 16'd1;
        if ($urandom_range(0, 99) < 70 && cur_win > 200) off = 16'($urandom_range(1, 200));
        r.seq_number = next_exp + off;
        if (seen_n < 16) begin
          k = seen_n;
          seen_n++;
        end else begin
          k = $urandom_range(0, 15);
        end
        seen_seq[k] = r.seq_number; seen_size[k] = r.packet_size; seen_src[k] = r.source_tag;
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 12) r.func = FN_POP_FIRST;
      else if (pick < 26) begin
        r.func = FN_POP_NUM;
        r.seq_number = (seen_n > 0) ? seen_seq[$urandom_range(0, seen_n - 1)] : 16'($urandom);
      end else if (pick < 34) r.func = FN_PEEK;
      else if (pick < 52) begin
        r.func = FN_TICK;
        r.elapsed_ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      end else if (pick < 62) begin
        r.func = FN_COUNT;
        r.timeout_ms = ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                       24'($urandom_range(0, 3000));
      end else if (pick < 85) begin
        r.func = FN_RESEND;
        r.timeout_ms = ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                       24'($urandom_range(0, 600));
        r.max_resend = 6'($urandom);
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = raw[$bits(req_t)-1:0];
      end
    end
    // let the window drift now and then
    if ($urandom_range(0, 99) < 5) next_exp = next_exp + 16'($urandom_range(1, 8));
    return r;
  endfunction

  task automatic run_random(input int n, input int insert_pct);
    for (int i = 0; i < n; i++) begin
      send(rand_req(insert_pct));
      // in runs of 80 or more, one hold-off in the middle: wait for every response
      if (n >= 80 && i == n / 2) wait_idle();
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed part, reset settings: window 32768, min size 10, type 3, scale 384
    calm = 1;
    send(mk(FN_POP_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0));          // empty list
    send(mk(FN_PEEK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_POP_NUM, 16'd5, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_RESEND, 0, 0, 0, 0, 0, 0, 0, 0, 6'd5));          // nothing to resend
    send(mk(FN_INSERT, 16'd5, 0, 8'd3, 16'd9, 0, 0, 0, 0, 0));  // too small
    send(mk(FN_INSERT, 16'd5, 0, 8'd4, 16'd10, 0, 0, 0, 0, 0)); // wrong type
    send(mk(FN_INSERT, 16'd32768, 0, 8'd3, 16'd10, 0, 0, 0, 0, 0)); // just past window
    send(mk(FN_INSERT, 16'd0, 0, 8'd3, 16'd10, 0, 0, 0, 0, 0));     // equals next expected
    send(mk(FN_INSERT, 16'd5, 0, 8'd3, 16'd10, 32'd7, 16'd50, 0, 0, 0));
    send(mk(FN_INSERT, 16'd3, 0, 8'd3, 16'd20, 32'd8, 16'd30, 0, 0, 0));
    send(mk(FN_INSERT, 16'd5, 0, 8'd3, 16'd10, 32'd7, 16'd51, 0, 0, 0)); // duplicate, same
    send(mk(FN_INSERT, 16'd5, 0, 8'd3, 16'd10, 32'd9, 16'd52, 0, 0, 0)); // duplicate, differs
    send(mk(FN_INSERT, 16'd32767, 0, 8'd3, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0, 0));
    send(mk(FN_INSERT, 16'd10, 16'hFFF0, 8'd3, 16'd10, 0, 16'd1, 0, 0, 0)); // wrapped window
    send(mk(FN_PEEK, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_TICK, 0, 0, 0, 0, 0, 0, 16'd1000, 0, 0));
    send(mk(FN_COUNT, 0, 0, 0, 0, 0, 0, 0, 24'd500, 0));
    send(mk(FN_RESEND, 0, 0, 0, 0, 0, 0, 0, 24'd500, 6'd0));    // zero acts as one
    send(mk(FN_RESEND, 0, 0, 0, 0, 0, 0, 0, 24'd0, 6'd63));     // above 32 acts as 32
    send(mk(FN_TICK, 0, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0));
    send(mk(FN_COUNT, 0, 0, 0, 0, 0, 0, 0, 24'hFF_FFFF, 0));
    send(mk(FN_POP_NUM, 16'd3, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_POP_NUM, 16'd999, 0, 0, 0, 0, 0, 0, 0, 0));       // not held
    send(mk(FN_POP_FIRST, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send(mk(FN_RESERVED, 0, 0, 0, 0, 0, 0, 0, 0, 0));            // unused code
    calm = 0;

    // insert-heavy to overflow the list, with a quiet stretch in the middle
    write_cfg(16'd32768, 16'd0, 8'd255, 10'd1023);
    run_random(50, 75);
    calm = 1;
    run_random(40, 75);
    calm = 0;

    // narrowest window, largest min size, scale of 1.0 (256)
    write_cfg(16'd1, 16'hFFFF, 8'd0, 10'd256);
    run_random(30, 50);

    // middling settings
    write_cfg(16'd1000, 16'd64, 8'd17, 10'd600);
    run_random(80, 45);

    req_valid = 1'b0;
    wait (pending == 0);
    repeat (500) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_seqnum_reorder_resend_buffer_top: PASS");
    end else begin
      $display("tb_seqnum_reorder_resend_buffer_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/srrb_pkg.sv
hw/rtl/seqnum_reorder_resend_buffer_top.sv
hw/rtl/srrb_checker.sv
tb/srrb_checker.sv
tb/tb_seqnum_reorder_resend_buffer_top.sv
